// ----- rtl/core/ir_climate_frame_transmitter_defines.svh -----
// ============================================================================
// IR climate frame transmitter assertion macros
// Concurrent assertion wrappers shared by the transmitter RTL.
// ============================================================================
`ifndef IR_CLIMATE_FRAME_TRANSMITTER_DEFINES_SVH
`define IR_CLIMATE_FRAME_TRANSMITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define ICFT_ASSERT_CLK(clk, rst, label, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ICFT_ASSERT(label, prop, msg) \
   `ICFT_ASSERT_CLK(clock, reset, label, prop, msg)

`else

`define ICFT_ASSERT_CLK(clk, rst, label, prop, msg)

`define ICFT_ASSERT(label, prop, msg)

`endif

`endif

// ----- rtl/core/icft_pkg.sv -----
// ============================================================================
// IR climate frame transmitter package
// Shared types, frame constants and register codes.
// ============================================================================
package icft_pkg;

   localparam int FRAME_BYTES = 13;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int POS_W       = $clog2(FRAME_BITS + 1);

   localparam logic [7:0] HEADER_BYTE = 8'b11000011;
   localparam logic [7:0] POWER_ON_BYTE = 8'b00000100;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   localparam logic [1:0] FAN_AUTO   = 2'd0;
   localparam logic [1:0] FAN_LOW    = 2'd1;
   localparam logic [1:0] FAN_MEDIUM = 2'd2;
   localparam logic [1:0] FAN_HIGH   = 2'd3;

   localparam logic [2:0] MODE_OFF       = 3'd0;
   localparam logic [2:0] MODE_HEAT_COOL = 3'd1;
   localparam logic [2:0] MODE_COOL      = 3'd2;
   localparam logic [2:0] MODE_HEAT      = 3'd3;
   localparam logic [2:0] MODE_FAN_ONLY  = 3'd4;
   localparam logic [2:0] MODE_DRY       = 3'd5;
   localparam logic [2:0] MODE_AUTO      = 3'd6;

   localparam logic [2:0] CSR_HEADER_MARK  = 3'd0;
   localparam logic [2:0] CSR_HEADER_SPACE = 3'd1;
   localparam logic [2:0] CSR_BIT_MARK     = 3'd2;
   localparam logic [2:0] CSR_ONE_SPACE    = 3'd3;
   localparam logic [2:0] CSR_ZERO_SPACE   = 3'd4;
   localparam logic [2:0] CSR_FOOTER_SPACE = 3'd5;
   localparam logic [2:0] CSR_TEMP_LOWER   = 3'd6;
   localparam logic [2:0] CSR_TEMP_UPPER   = 3'd7;

   localparam logic [15:0] RST_HEADER_MARK  = 16'd8950;
   localparam logic [15:0] RST_HEADER_SPACE = 16'd4530;
   localparam logic [15:0] RST_BIT_MARK     = 16'd563;
   localparam logic [15:0] RST_ONE_SPACE    = 16'd1690;
   localparam logic [15:0] RST_ZERO_SPACE   = 16'd538;
   localparam logic [15:0] RST_FOOTER_SPACE = 16'd10000;
   localparam logic [5:0]  RST_TEMP_LOWER   = 6'd16;
   localparam logic [5:0]  RST_TEMP_UPPER   = 6'd30;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HDR_MARK  = 3'd1,
      PH_HDR_SPACE = 3'd2,
      PH_BIT_MARK  = 3'd3,
      PH_BIT_SPACE = 3'd4,
      PH_FTR_MARK  = 3'd5,
      PH_FTR_SPACE = 3'd6
   } phase_type;

   typedef struct packed {
      logic       swing_vertical;
      logic [5:0] target_temp;
      logic [1:0] fan_speed;
      logic [2:0] climate_mode;
      logic [5:0] temp_lower_limit;
      logic [5:0] temp_upper_limit;
   } send_req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] bits;
      logic [1:0]            fan;
   } frame_type;

   typedef struct packed {
      logic       ir_envelope;
      logic       busy_res;
      logic       send_accepted;
      logic [1:0] fan_effective;
   } rsp_item_type;

endpackage

// ----- rtl/core/icft_frame_builder.sv -----
// ============================================================================
// IR climate frame builder
// Builds the 13-byte climate command frame and its checksum from a send item.
// ============================================================================
module icft_frame_builder (
   input  icft_pkg::send_req_type req,
   output icft_pkg::frame_type    frame
);

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   logic [5:0] clamped;
   logic [4:0] temp_code;
   logic [1:0] fan;
   logic [7:0] fan_code;
   logic [7:0] mode_code;
   logic [7:0] bytes [icft_pkg::FRAME_BYTES];
   logic [7:0] sum_a;
   logic [7:0] sum_b;
   logic [7:0] sum;

   always_comb begin
      if (req.target_temp < req.temp_lower_limit) begin
         clamped = req.temp_lower_limit;
      end else if (req.target_temp > req.temp_upper_limit) begin
         clamped = req.temp_upper_limit;
      end else begin
         clamped = req.target_temp;
      end
      temp_code = clamped[4:0] - 5'd8;

      fan = req.fan_speed;
      if (req.climate_mode == icft_pkg::MODE_DRY ||
          (req.climate_mode == icft_pkg::MODE_FAN_ONLY && req.fan_speed == icft_pkg::FAN_AUTO))
      begin
         fan = icft_pkg::FAN_LOW;
      end

      case (fan)
         icft_pkg::FAN_AUTO:   fan_code = 8'b00000101;
         icft_pkg::FAN_LOW:    fan_code = 8'b00000110;
         icft_pkg::FAN_MEDIUM: fan_code = 8'b00000010;
         default:              fan_code = 8'b00000100;
      endcase

      case (req.climate_mode)
         icft_pkg::MODE_COOL:     mode_code = 8'b00000100;
         icft_pkg::MODE_HEAT:     mode_code = 8'b00000001;
         icft_pkg::MODE_FAN_ONLY: mode_code = 8'b00000011;
         icft_pkg::MODE_DRY:      mode_code = 8'b00000010;
         default:                 mode_code = 8'b00000000;
      endcase

      for (int i = 0; i < icft_pkg::FRAME_BYTES; i++) begin
         bytes[i] = 8'd0;
      end
      bytes[0] = icft_pkg::HEADER_BYTE;
      bytes[1] = {{3{~req.swing_vertical}},
                  temp_code[0], temp_code[1], temp_code[2], temp_code[3], temp_code[4]};
      bytes[4] = fan_code;
      if (req.climate_mode != icft_pkg::MODE_OFF) begin
         bytes[6] = mode_code;
         bytes[9] = icft_pkg::POWER_ON_BYTE;
      end

      // Only bytes 0, 1, 4, 6 and 9 can be nonzero ahead of the checksum.
      sum_a = rev8(bytes[0]) + rev8(bytes[1]);
      sum_b = rev8(bytes[4]) + rev8(bytes[6]) + rev8(bytes[9]);
      sum   = sum_a + sum_b;
      bytes[icft_pkg::FRAME_BYTES - 1] = rev8(sum);

      for (int i = 0; i < icft_pkg::FRAME_BYTES; i++) begin
         frame.bits[icft_pkg::FRAME_BITS - 1 - 8 * i -: 8] = bytes[i];
      end
      frame.fan = fan;
   end

endmodule

// ----- rtl/core/ir_climate_frame_transmitter.sv -----
// ============================================================================
// IR climate frame transmitter
// Pulse-distance envelope encoder for a 13-byte climate command frame.
// ============================================================================
// Each item is either a one-microsecond tick or a send request, and the block
// takes one item every clock cycle while req_stall is low. An item updates the
// envelope sequencer in the cycle it is accepted and its result is registered
// into a two-entry output buffer, which holds results while rsp_stall is high;
// req_stall rises only once both entries are full. A send while a frame is on
// the air is refused with send_accepted low. Configuration writes are always
// ready and take effect on the next item. No clearing pass follows reset.
`include "ir_climate_frame_transmitter_defines.svh"

module ir_climate_frame_transmitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic        req_swing_vertical,
   input  logic [5:0]  req_target_temp,
   input  logic [1:0]  req_fan_speed,
   input  logic [2:0]  req_climate_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ir_envelope,
   output logic        rsp_busy_res,
   output logic        rsp_send_accepted,
   output logic [1:0]  rsp_fan_effective,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   function automatic logic [15:0] len_of(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   logic [15:0] header_mark_ff;
   logic [15:0] header_space_ff;
   logic [15:0] pulse_mark_ff;
   logic [15:0] ones_gap_ff;
   logic [15:0] zeros_gap_ff;
   logic [15:0] footer_space_ff;
   logic [5:0]  temp_lower_ff;
   logic [5:0]  temp_upper_ff;

   icft_pkg::phase_type              phase_ff, phase_in;
   logic [15:0]                      ticks_ff, ticks_in;
   logic [icft_pkg::POS_W-1:0]       bit_pos_ff, bit_pos_in;
   logic [icft_pkg::FRAME_BITS-1:0]  frame_ff, frame_in;
   logic [1:0]                       fan_ff, fan_in;

   icft_pkg::rsp_item_type out_ff, out_in;
   icft_pkg::rsp_item_type skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   icft_pkg::send_req_type send_req;
   icft_pkg::frame_type    built;
   icft_pkg::rsp_item_type result;
   icft_pkg::phase_type    env_phase;
   logic                   req_accept;
   logic                   rsp_take;
   logic                   accepted;
   logic [icft_pkg::POS_W-1:0] bit_pos_next;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   assign send_req.swing_vertical   = req_swing_vertical;
   assign send_req.target_temp      = req_target_temp;
   assign send_req.fan_speed        = req_fan_speed;
   assign send_req.climate_mode     = req_climate_mode;
   assign send_req.temp_lower_limit = temp_lower_ff;
   assign send_req.temp_upper_limit = temp_upper_ff;

   icft_frame_builder u_builder (
      .req   (send_req),
      .frame (built)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         header_mark_ff  <= icft_pkg::RST_HEADER_MARK;
         header_space_ff <= icft_pkg::RST_HEADER_SPACE;
         pulse_mark_ff   <= icft_pkg::RST_BIT_MARK;
         ones_gap_ff     <= icft_pkg::RST_ONE_SPACE;
         zeros_gap_ff    <= icft_pkg::RST_ZERO_SPACE;
         footer_space_ff <= icft_pkg::RST_FOOTER_SPACE;
         temp_lower_ff   <= icft_pkg::RST_TEMP_LOWER;
         temp_upper_ff   <= icft_pkg::RST_TEMP_UPPER;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            icft_pkg::CSR_HEADER_MARK:  header_mark_ff  <= csr_data;
            icft_pkg::CSR_HEADER_SPACE: header_space_ff <= csr_data;
            icft_pkg::CSR_BIT_MARK:     pulse_mark_ff   <= csr_data;
            icft_pkg::CSR_ONE_SPACE:    ones_gap_ff     <= csr_data;
            icft_pkg::CSR_ZERO_SPACE:   zeros_gap_ff    <= csr_data;
            icft_pkg::CSR_FOOTER_SPACE: footer_space_ff <= csr_data;
            icft_pkg::CSR_TEMP_LOWER:   temp_lower_ff   <= csr_data[5:0];
            icft_pkg::CSR_TEMP_UPPER:   temp_upper_ff   <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= icft_pkg::PH_IDLE;
         ticks_ff   <= 16'd0;
         bit_pos_ff <= '0;
         frame_ff   <= '0;
         fan_ff     <= icft_pkg::FAN_LOW;
      end else begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         bit_pos_ff <= bit_pos_in;
         frame_ff   <= frame_in;
         fan_ff     <= fan_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      bit_pos_in   = bit_pos_ff;
      frame_in     = frame_ff;
      fan_in       = fan_ff;
      accepted     = 1'b0;
      bit_pos_next = bit_pos_ff + icft_pkg::POS_W'(1);

      if (req_accept) begin
         if (req_type == icft_pkg::REQ_SEND) begin
            if (phase_ff == icft_pkg::PH_IDLE) begin
               frame_in   = built.bits;
               fan_in     = built.fan;
               bit_pos_in = '0;
               phase_in   = icft_pkg::PH_HDR_MARK;
               ticks_in   = len_of(header_mark_ff);
               accepted   = 1'b1;
            end
         end else if (phase_ff != icft_pkg::PH_IDLE) begin
            if (ticks_ff > 16'd1) begin
               ticks_in = ticks_ff - 16'd1;
            end else begin
               unique case (phase_ff)
                  icft_pkg::PH_HDR_MARK: begin
                     phase_in = icft_pkg::PH_HDR_SPACE;
                     ticks_in = len_of(header_space_ff);
                  end
                  icft_pkg::PH_HDR_SPACE: begin
                     bit_pos_in = '0;
                     phase_in   = icft_pkg::PH_BIT_MARK;
                     ticks_in   = len_of(pulse_mark_ff);
                  end
                  icft_pkg::PH_BIT_MARK: begin
                     phase_in = icft_pkg::PH_BIT_SPACE;
                     ticks_in = len_of(frame_ff[icft_pkg::FRAME_BITS-1] ?
                                       ones_gap_ff : zeros_gap_ff);
                  end
                  icft_pkg::PH_BIT_SPACE: begin
                     bit_pos_in = bit_pos_next;
                     frame_in   = {frame_ff[icft_pkg::FRAME_BITS-2:0], 1'b0};
                     ticks_in   = len_of(pulse_mark_ff);
                     if (bit_pos_next >= icft_pkg::POS_W'(icft_pkg::FRAME_BITS)) begin
                        phase_in = icft_pkg::PH_FTR_MARK;
                     end else begin
                        phase_in = icft_pkg::PH_BIT_MARK;
                     end
                  end
                  icft_pkg::PH_FTR_MARK: begin
                     phase_in = icft_pkg::PH_FTR_SPACE;
                     ticks_in = len_of(footer_space_ff);
                  end
                  default: begin
                     phase_in   = icft_pkg::PH_IDLE;
                     ticks_in   = 16'd0;
                     bit_pos_in = '0;
                  end
               endcase
            end
         end
      end

      // A send reports the level after it, a tick the level before it.
      env_phase = (req_type == icft_pkg::REQ_SEND) ? phase_in : phase_ff;

      result.ir_envelope   = (env_phase == icft_pkg::PH_HDR_MARK) ||
                             (env_phase == icft_pkg::PH_BIT_MARK) ||
                             (env_phase == icft_pkg::PH_FTR_MARK);
      result.busy_res      = (phase_in != icft_pkg::PH_IDLE);
      result.send_accepted = accepted;
      result.fan_effective = fan_in;
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_ir_envelope   = out_ff.ir_envelope;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_send_accepted = out_ff.send_accepted;
   assign rsp_fan_effective = out_ff.fan_effective;

   `ICFT_ASSERT(a_skid_needs_out, skid_valid_ff |-> out_valid_ff, "skid entry without output entry")
   `ICFT_ASSERT(a_active_has_ticks, (phase_ff != icft_pkg::PH_IDLE) |-> (ticks_ff != 16'd0), "active phase with zero ticks")
   `ICFT_ASSERT(a_bit_pos_range, bit_pos_ff <= icft_pkg::POS_W'(icft_pkg::FRAME_BITS), "bit position past frame end")
   `ICFT_ASSERT(a_send_starts_header, (req_accept && req_type == icft_pkg::REQ_SEND && phase_ff == icft_pkg::PH_IDLE) |=> (phase_ff == icft_pkg::PH_HDR_MARK), "accepted send did not start header mark")

endmodule
